/* rtl/core/fhid_pkg.sv */
// Shared types, constants and code tables for the fixed-code inflate decoder.
// Depends on nothing; only the top level, fixed_huffman_inflate_decoder, imports it.
package fhid_pkg;

    localparam int WINDOW_SIZE = 32768;
    localparam int HIST_AW     = $clog2(WINDOW_SIZE);
    localparam int LANE_BYTES  = 8;
    localparam int LANE_W      = 8 * LANE_BYTES;
    localparam int LANE_IW     = $clog2(LANE_BYTES);
    localparam int LANE_CW     = $clog2(LANE_BYTES + 1);
    localparam int CNT_W       = 24;
    localparam int DIST_W      = 16;

    typedef enum logic [2:0] {
        STS_DATA,
        STS_DONE,
        STS_BAD_HEADER,
        STS_BAD_SYMBOL,
        STS_BAD_DIST,
        STS_TOO_FAR,
        STS_OVERFLOW,
        STS_TRUNCATED
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SYMBOL,
        PH_LEN_EXTRA,
        PH_DIST_CODE,
        PH_DIST_EXTRA,
        PH_FINISHED
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_BIT,
        SEQ_RD,
        SEQ_WR,
        SEQ_LANE,
        SEQ_STAT,
        SEQ_END
    } seq_t;

    // What one decoded bit asks the sequencer to do.
    typedef struct packed {
        logic              emit;
        logic [7:0]        lit;
        logic              fin;
        status_t           fin_st;
        logic              copy;
        logic [DIST_W-1:0] back_dist;
    } bit_act_t;

    function automatic logic [8:0] len_base(input logic [4:0] idx);
        logic [8:0] r;
        unique case (idx)
            5'd0:  r = 9'd3;   5'd1:  r = 9'd4;   5'd2:  r = 9'd5;   5'd3:  r = 9'd6;
            5'd4:  r = 9'd7;   5'd5:  r = 9'd8;   5'd6:  r = 9'd9;   5'd7:  r = 9'd10;
            5'd8:  r = 9'd11;  5'd9:  r = 9'd13;  5'd10: r = 9'd15;  5'd11: r = 9'd17;
            5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;  5'd15: r = 9'd31;
            5'd16: r = 9'd35;  5'd17: r = 9'd43;  5'd18: r = 9'd51;  5'd19: r = 9'd59;
            5'd20: r = 9'd67;  5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
            5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195; 5'd27: r = 9'd227;
            5'd28: r = 9'd258;
            default: r = 9'd3;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] len_bits(input logic [4:0] idx);
        logic [2:0] r;
        if (idx >= 5'd8 && idx <= 5'd27)
        begin
            r = 3'(((idx - 5'd8) >> 2) + 5'd1);
        end
        else
        begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [14:0] dist_base(input logic [4:0] idx);
        logic [14:0] r;
        unique case (idx)
            5'd0:  r = 15'd1;     5'd1:  r = 15'd2;     5'd2:  r = 15'd3;
            5'd3:  r = 15'd4;     5'd4:  r = 15'd5;     5'd5:  r = 15'd7;
            5'd6:  r = 15'd9;     5'd7:  r = 15'd13;    5'd8:  r = 15'd17;
            5'd9:  r = 15'd25;    5'd10: r = 15'd33;    5'd11: r = 15'd49;
            5'd12: r = 15'd65;    5'd13: r = 15'd97;    5'd14: r = 15'd129;
            5'd15: r = 15'd193;   5'd16: r = 15'd257;   5'd17: r = 15'd385;
            5'd18: r = 15'd513;   5'd19: r = 15'd769;   5'd20: r = 15'd1025;
            5'd21: r = 15'd1537;  5'd22: r = 15'd2049;  5'd23: r = 15'd3073;
            5'd24: r = 15'd4097;  5'd25: r = 15'd6145;  5'd26: r = 15'd8193;
            5'd27: r = 15'd12289; 5'd28: r = 15'd16385; 5'd29: r = 15'd24577;
            default: r = 15'd1;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] dist_bits(input logic [4:0] idx);
        logic [3:0] r;
        if (idx >= 5'd4 && idx <= 5'd29)
        begin
            r = 4'((idx >> 1) - 5'd1);
        end
        else
        begin
            r = 4'd0;
        end
        return r;
    endfunction

    // Fixed literal/length code: returns {valid, symbol}.
    function automatic logic [9:0] fixed_symbol(input logic [8:0] acc, input logic [3:0] n);
        logic [9:0] r;
        r = 10'd0;
        if (n == 4'd7 && acc <= 9'd23)
        begin
            r = {1'b1, 9'(9'd256 + acc)};
        end
        else if (n == 4'd8 && acc >= 9'h030 && acc <= 9'h0bf)
        begin
            r = {1'b1, 9'(acc - 9'h030)};
        end
        else if (n == 4'd8 && acc >= 9'h0c0 && acc <= 9'h0c7)
        begin
            r = {1'b1, 9'(9'd280 + acc - 9'h0c0)};
        end
        else if (n == 4'd9 && acc >= 9'h190)
        begin
            r = {1'b1, 9'(9'd144 + acc - 9'h190)};
        end
        else if (n == 4'd9)
        begin
            r = {1'b1, 9'd287};
        end
        return r;
    endfunction

endpackage

/* rtl/core/fhid_in_if.sv */
// Channel carrying compressed words into the decoder.
// Depends on nothing.
interface fhid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

/* rtl/core/fhid_out_if.sv */
// Channel carrying decoded words and status out of the decoder.
// Depends on nothing.
interface fhid_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic [2:0]  status;
    logic [23:0] total_length;
    logic        last;

    modport source (output valid, output out_bytes, output byte_count, output status,
                    output total_length, output last, input ready);
    modport sink   (input valid, input out_bytes, input byte_count, input status,
                    input total_length, input last, output ready);
endinterface

/* rtl/core/fhid_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module fhid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/fixed_huffman_inflate_decoder.sv */
// Top level of the fixed-code inflate decoder: bit-serial decode, history RAM, lane packing.
// Depends on fhid_pkg, fhid_in_if, fhid_out_if and fhid_ram.
//
//  channel      dir  handshake      payload
//  compressed   in   valid/ready    in_byte[7:0], last_byte
//  decoded      out  valid/ready    out_bytes[63:0], byte_count[3:0], status[2:0],
//                                   total_length[23:0], last
//  cfg_wr_*     in   write enable   cfg_wr_data[23:0] = out_capacity
//
// Each compressed word is decoded one bit per cycle unless a copy or a stalled output
// holds the sequencer: SEQ_IDLE accepts it, SEQ_BIT decodes its eight bits, SEQ_END
// closes it, full lanes go out from SEQ_LANE and a stream cut short passes SEQ_STAT.
// A back-reference copies through the history RAM one byte at a time: SEQ_RD reads
// the byte and SEQ_WR writes it before the next read, so a match at distance one sees
// the byte just written; the input is held until the whole match is written.
// Reset clears control and stream state but not byte_reg, copy_dist_reg, out data or RAM.
// A stalled output holds the sequencer wherever it next wants to push a word.
module fixed_huffman_inflate_decoder
    import fhid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    fhid_in_if.sink            compressed,
    fhid_out_if.source         decoded,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data
);

    // Sequencer and the word being decoded.
    seq_t              state_reg, state_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;

    // Stream state of the deflate block.
    phase_t            phase_reg, phase_next;
    logic [12:0]       buf_reg, buf_next;
    logic [3:0]        fill_reg, fill_next;
    logic [8:0]        acc_reg, acc_next;
    logic [3:0]        clen_reg, clen_next;
    logic [8:0]        plen_reg, plen_next;
    logic [4:0]        pdist_reg, pdist_next;
    logic [CNT_W-1:0]  prod_reg, prod_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    status_t           st_reg, st_next;

    // Lane being packed and the copy in progress.
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [LANE_CW-1:0] lane_n_reg, lane_n_next;
    logic [8:0]        copy_rem_reg, copy_rem_next;
    logic [DIST_W-1:0] copy_dist_reg, copy_dist_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [LANE_W-1:0] out_bytes_reg, out_bytes_next;
    logic [3:0]        out_cnt_reg, out_cnt_next;
    status_t           out_st_reg, out_st_next;
    logic [CNT_W-1:0]  out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;

    // Bit decoder results.
    bit_act_t          act;
    phase_t            d_phase;
    logic [12:0]       d_buf;
    logic [3:0]        d_fill;
    logic [8:0]        d_acc;
    logic [3:0]        d_clen;
    logic [8:0]        d_plen;
    logic [4:0]        d_pdist;

    logic              space;
    logic              lane_full;
    seq_t              cont_state;

    // History RAM signals.
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [CNT_W-1:0]  rd_pos;

    assign space      = !out_valid_reg || decoded.ready;
    assign lane_full  = (lane_n_reg == LANE_CW'(LANE_BYTES - 1));
    assign cont_state = (bit_cnt_reg == 4'd8) ? SEQ_END : SEQ_BIT;

    assign compressed.ready    = (state_reg == SEQ_IDLE);
    assign decoded.valid       = out_valid_reg;
    assign decoded.out_bytes   = out_bytes_reg;
    assign decoded.byte_count  = out_cnt_reg;
    assign decoded.status      = out_st_reg;
    assign decoded.total_length = out_len_reg;
    assign decoded.last        = out_last_reg;

    // The copy source trails the write pointer by the match distance.
    assign rd_pos    = prod_reg - CNT_W'(copy_dist_reg);
    assign ram_we    = (state_reg == SEQ_BIT && act.emit) || (state_reg == SEQ_WR);
    assign ram_wdata = (state_reg == SEQ_BIT) ? act.lit : ram_rdata;

    fhid_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (prod_reg[HIST_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_pos[HIST_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Decode of the current compressed bit against the stream state.
    always_comb
    begin
        logic       b;
        logic [12:0] nbuf;
        logic [3:0] fill1;
        logic [8:0] acc1;
        logic [4:0] acc5;
        logic [3:0] clen1;
        logic [9:0] fs;
        logic [4:0] idx;
        logic       want_copy;
        logic [DIST_W-1:0] cdist;

        b     = byte_reg[bit_cnt_reg[2:0]];
        nbuf  = buf_reg | (13'(b) << fill_reg);
        fill1 = fill_reg + 4'd1;
        acc1  = {acc_reg[7:0], b};
        acc5  = {acc_reg[3:0], b};
        clen1 = clen_reg + 4'd1;
        fs    = fixed_symbol(acc1, clen1);
        idx   = 5'd0;
        want_copy = 1'b0;
        cdist = '0;

        act     = '0;
        act.fin_st = STS_DATA;
        d_phase = phase_reg;
        d_buf   = buf_reg;
        d_fill  = fill_reg;
        d_acc   = acc_reg;
        d_clen  = clen_reg;
        d_plen  = plen_reg;
        d_pdist = pdist_reg;

        unique case (phase_reg)
            PH_HEADER:
            begin
                d_buf  = nbuf;
                d_fill = fill1;
                if (fill1 >= 4'd3)
                begin
                    if (nbuf == 13'd3)
                    begin
                        d_buf   = '0;
                        d_fill  = '0;
                        d_phase = PH_SYMBOL;
                    end
                    else
                    begin
                        act.fin    = 1'b1;
                        act.fin_st = STS_BAD_HEADER;
                    end
                end
            end
            PH_SYMBOL:
            begin
                d_acc  = acc1;
                d_clen = clen1;
                if (fs[9])
                begin
                    d_acc  = '0;
                    d_clen = '0;
                    if (fs[8:0] < 9'd256)
                    begin
                        if (prod_reg >= cap_reg)
                        begin
                            act.fin    = 1'b1;
                            act.fin_st = STS_OVERFLOW;
                        end
                        else
                        begin
                            act.emit = 1'b1;
                            act.lit  = fs[7:0];
                        end
                    end
                    else if (fs[8:0] == 9'd256)
                    begin
                        act.fin    = 1'b1;
                        act.fin_st = STS_DONE;
                    end
                    else if (fs[8:0] <= 9'd285)
                    begin
                        idx    = 5'(fs[8:0] - 9'd257);
                        d_plen = len_base(idx);
                        d_buf  = '0;
                        d_fill = '0;
                        if (len_bits(idx) == 3'd0)
                        begin
                            d_phase = PH_DIST_CODE;
                        end
                        else
                        begin
                            d_acc   = 9'(idx);
                            d_phase = PH_LEN_EXTRA;
                        end
                    end
                    else
                    begin
                        act.fin    = 1'b1;
                        act.fin_st = STS_BAD_SYMBOL;
                    end
                end
            end
            PH_LEN_EXTRA:
            begin
                idx    = acc_reg[4:0];
                d_buf  = nbuf;
                d_fill = fill1;
                if (fill1 >= 4'(len_bits(idx)))
                begin
                    d_plen  = len_base(idx) + 9'(nbuf[4:0]);
                    d_buf   = '0;
                    d_fill  = '0;
                    d_acc   = '0;
                    d_phase = PH_DIST_CODE;
                end
            end
            PH_DIST_CODE:
            begin
                d_acc  = 9'(acc5);
                d_clen = clen1;
                if (clen1 >= 4'd5)
                begin
                    d_acc  = '0;
                    d_clen = '0;
                    if (acc5 >= 5'd30)
                    begin
                        act.fin    = 1'b1;
                        act.fin_st = STS_BAD_DIST;
                    end
                    else
                    begin
                        d_pdist = acc5;
                        d_buf   = '0;
                        d_fill  = '0;
                        if (dist_bits(acc5) == 4'd0)
                        begin
                            want_copy = 1'b1;
                            cdist     = DIST_W'(dist_base(acc5));
                        end
                        else
                        begin
                            d_phase = PH_DIST_EXTRA;
                        end
                    end
                end
            end
            PH_DIST_EXTRA:
            begin
                idx    = (pdist_reg < 5'd30) ? pdist_reg : 5'd0;
                d_buf  = nbuf;
                d_fill = fill1;
                if (fill1 >= dist_bits(idx))
                begin
                    want_copy = 1'b1;
                    cdist     = DIST_W'(dist_base(idx)) + DIST_W'(nbuf);
                end
            end
            PH_FINISHED:
            begin
            end
            default:
            begin
            end
        endcase

        // Range and capacity checks come before any byte of the match is written.
        if (want_copy)
        begin
            d_buf   = '0;
            d_fill  = '0;
            d_phase = PH_SYMBOL;
            if (CNT_W'(cdist) > prod_reg)
            begin
                act.fin    = 1'b1;
                act.fin_st = STS_TOO_FAR;
            end
            else if ((25'(prod_reg) + 25'(plen_reg)) > 25'(cap_reg))
            begin
                act.fin    = 1'b1;
                act.fin_st = STS_OVERFLOW;
            end
            else
            begin
                act.copy      = 1'b1;
                act.back_dist = cdist;
            end
        end

        if (act.fin)
        begin
            d_phase = PH_FINISHED;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (compressed.valid)
                begin
                    state_next = SEQ_BIT;
                end
            end
            SEQ_BIT:
            begin
                if (act.fin)
                begin
                    state_next = SEQ_STAT;
                end
                else if (act.copy)
                begin
                    state_next = SEQ_RD;
                end
                else if (act.emit && lane_full)
                begin
                    state_next = SEQ_LANE;
                end
                else if (bit_cnt_reg == 4'd7)
                begin
                    state_next = SEQ_END;
                end
                else
                begin
                    state_next = SEQ_BIT;
                end
            end
            SEQ_RD:
            begin
                state_next = SEQ_WR;
            end
            SEQ_WR:
            begin
                if (lane_full)
                begin
                    state_next = SEQ_LANE;
                end
                else if (copy_rem_reg == 9'd1)
                begin
                    state_next = cont_state;
                end
                else
                begin
                    state_next = SEQ_RD;
                end
            end
            SEQ_LANE:
            begin
                if (space)
                begin
                    state_next = (copy_rem_reg != 9'd0) ? SEQ_RD : cont_state;
                end
            end
            SEQ_STAT:
            begin
                if (space && lane_n_reg == '0)
                begin
                    state_next = cont_state;
                end
            end
            SEQ_END:
            begin
                if (last_reg && phase_reg != PH_FINISHED)
                begin
                    state_next = SEQ_STAT;
                end
                else if (lane_n_reg == '0)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        byte_next      = byte_reg;
        last_next      = last_reg;
        bit_cnt_next   = bit_cnt_reg;
        phase_next     = phase_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        clen_next      = clen_reg;
        plen_next      = plen_reg;
        pdist_next     = pdist_reg;
        prod_next      = prod_reg;
        st_next        = st_reg;
        lane_next      = lane_reg;
        lane_n_next    = lane_n_reg;
        copy_rem_next  = copy_rem_reg;
        copy_dist_next = copy_dist_reg;
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;

        out_valid_next = (out_valid_reg && !decoded.ready) ? 1'b1 : 1'b0;
        out_bytes_next = out_bytes_reg;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (compressed.valid)
                begin
                    byte_next    = compressed.in_byte;
                    last_next    = compressed.last_byte;
                    bit_cnt_next = '0;
                end
            end
            SEQ_BIT:
            begin
                bit_cnt_next = bit_cnt_reg + 4'd1;
                phase_next   = d_phase;
                buf_next     = d_buf;
                fill_next    = d_fill;
                acc_next     = d_acc;
                clen_next    = d_clen;
                plen_next    = d_plen;
                pdist_next   = d_pdist;
                if (act.fin)
                begin
                    st_next = act.fin_st;
                end
                if (act.emit)
                begin
                    prod_next = prod_reg + CNT_W'(1);
                    lane_next[8 * lane_n_reg[LANE_IW-1:0] +: 8] = act.lit;
                    lane_n_next = lane_n_reg + LANE_CW'(1);
                end
                if (act.copy)
                begin
                    copy_rem_next  = plen_reg;
                    copy_dist_next = act.back_dist;
                end
            end
            SEQ_RD:
            begin
            end
            SEQ_WR:
            begin
                prod_next = prod_reg + CNT_W'(1);
                lane_next[8 * lane_n_reg[LANE_IW-1:0] +: 8] = ram_rdata;
                lane_n_next   = lane_n_reg + LANE_CW'(1);
                copy_rem_next = copy_rem_reg - 9'd1;
            end
            SEQ_LANE:
            begin
                if (space)
                begin
                    out_valid_next = 1'b1;
                    out_bytes_next = lane_reg;
                    out_cnt_next   = 4'(lane_n_reg);
                    out_st_next    = STS_DATA;
                    out_len_next   = prod_reg;
                    out_last_next  = 1'b0;
                    lane_next      = '0;
                    lane_n_next    = '0;
                end
            end
            SEQ_STAT:
            begin
                if (space)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = prod_reg;
                    if (lane_n_reg != '0)
                    begin
                        // A partial lane goes out ahead of the closing status.
                        out_bytes_next = lane_reg;
                        out_cnt_next   = 4'(lane_n_reg);
                        out_st_next    = STS_DATA;
                        out_last_next  = 1'b0;
                        lane_next      = '0;
                        lane_n_next    = '0;
                    end
                    else
                    begin
                        out_bytes_next = '0;
                        out_cnt_next   = '0;
                        out_st_next    = st_reg;
                        out_last_next  = 1'b1;
                    end
                end
            end
            SEQ_END:
            begin
                if (last_reg && phase_reg != PH_FINISHED)
                begin
                    st_next    = STS_TRUNCATED;
                    phase_next = PH_FINISHED;
                end
                else if (lane_n_reg != '0)
                begin
                    if (space)
                    begin
                        out_valid_next = 1'b1;
                        out_bytes_next = lane_reg;
                        out_cnt_next   = 4'(lane_n_reg);
                        out_st_next    = STS_DATA;
                        out_len_next   = prod_reg;
                        out_last_next  = 1'b0;
                        lane_next      = '0;
                        lane_n_next    = '0;
                    end
                end
                else if (last_reg)
                begin
                    // End of the compressed stream: start over for the next one.
                    phase_next = PH_HEADER;
                    buf_next   = '0;
                    fill_next  = '0;
                    acc_next   = '0;
                    clen_next  = '0;
                    plen_next  = '0;
                    pdist_next = '0;
                    prod_next  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            last_reg      <= 1'b0;
            bit_cnt_reg   <= '0;
            phase_reg     <= PH_HEADER;
            buf_reg       <= '0;
            fill_reg      <= '0;
            acc_reg       <= '0;
            clen_reg      <= '0;
            plen_reg      <= '0;
            pdist_reg     <= '0;
            prod_reg      <= '0;
            cap_reg       <= '1;
            st_reg        <= STS_DATA;
            lane_reg      <= '0;
            lane_n_reg    <= '0;
            copy_rem_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            bit_cnt_reg   <= bit_cnt_next;
            phase_reg     <= phase_next;
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            acc_reg       <= acc_next;
            clen_reg      <= clen_next;
            plen_reg      <= plen_next;
            pdist_reg     <= pdist_next;
            prod_reg      <= prod_next;
            cap_reg       <= cap_next;
            st_reg        <= st_next;
            lane_reg      <= lane_next;
            lane_n_reg    <= lane_n_next;
            copy_rem_reg  <= copy_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        copy_dist_reg <= copy_dist_next;
        out_bytes_reg <= out_bytes_next;
        out_cnt_reg   <= out_cnt_next;
        out_st_reg    <= out_st_next;
        out_len_reg   <= out_len_next;
        out_last_reg  <= out_last_next;
    end

endmodule
